@@ src/u8sd_pkg.sv @@
`default_nettype none

package u8sd_pkg;

    // Field widths fixed by the interface
    localparam int BYTE_BITS      = 8;
    localparam int CP_BITS        = 16;
    localparam int LEN_BITS       = 4;
    localparam int LEFT_BITS      = 3;
    localparam int CNT_OUT_BITS   = 16;
    localparam int LIMIT_BITS     = 16;

    // Character counter width default
    localparam int COUNT_BITS_DEF = 16;

    // Configuration port
    localparam int APB_ADDR_BITS  = 3;
    localparam int APB_DATA_BITS  = 32;
    localparam logic [APB_ADDR_BITS-1:0] REG_CHAR_LIMIT_ADDR = 3'h0;
    localparam logic [LIMIT_BITS-1:0]    CHAR_LIMIT_RESET    = 16'hFFFF;

    // Byte classification masks and patterns
    localparam logic [7:0] ASCII_TOP    = 8'h80;
    localparam logic [7:0] MASK_E0      = 8'hE0;
    localparam logic [7:0] MASK_F0      = 8'hF0;
    localparam logic [7:0] MASK_C0      = 8'hC0;
    localparam logic [7:0] LEAD2_PAT    = 8'hC0;
    localparam logic [7:0] LEAD3_PAT    = 8'hE0;
    localparam logic [7:0] CONT_PAT     = 8'h80;
    localparam logic [7:0] PAY2_MASK    = 8'h1F;
    localparam logic [7:0] PAY3_MASK    = 8'h0F;
    localparam logic [7:0] CONT_MASK    = 8'h3F;

    // Count of leading ones of a byte, 0..8
    function automatic logic [LEN_BITS-1:0] leading_ones(input logic [BYTE_BITS-1:0] b);
        logic [LEN_BITS-1:0] n;
        logic                run;
        n   = '0;
        run = 1'b1;
        for (int i = BYTE_BITS - 1; i >= 0; i--)
        begin
            run = run & b[i];
            if (run)
            begin
                n = n + LEN_BITS'(1);
            end
        end
        return n;
    endfunction

endpackage

`default_nettype wire

@@ src/utf8_stream_decoder_unit.sv @@
`default_nettype none

// Channel   Direction  Handshake                 Payload
// input     in         in_valid / in_stall       data_byte[7:0]
// output    out        out_valid / out_stall     code_point[15:0], seq_length[3:0],
//                                                char_count[15:0], end_of_string,
//                                                limit_reached
// config    in         APB psel/penable/pwrite   paddr[2:0], pwdata[31:0] -> prdata[31:0]
//
// One byte is taken per cycle while in_stall is low. A character result
// appears in the output register in the cycle after the transfer of its last byte
// (or of the zero byte that ends a string); lead and middle bytes of a
// sequence give no result. The sequence state and counter update form a
// feedback loop, one pass of short logic from the accepted byte to the registers.
// in_stall rises only while a result waits in the output register and the
// sink stalls it. Reset clears the sequence state, the counter, the output
// valid and sets char_limit to 65535.

module utf8_stream_decoder_unit
    import u8sd_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,

    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic [BYTE_BITS-1:0]     data_byte,

    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic [CP_BITS-1:0]            code_point,
    output logic [LEN_BITS-1:0]           seq_length,
    output logic [CNT_OUT_BITS-1:0]       char_count,
    output logic                          end_of_string,
    output logic                          limit_reached,

    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [APB_ADDR_BITS-1:0] paddr,
    input  wire logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0]      prdata,
    output logic                          pready
);

    // Common width for counter/limit compares and the count output
    localparam int WIDE_BITS = (COUNT_BITS > LIMIT_BITS) ?
                               ((COUNT_BITS > CNT_OUT_BITS) ? COUNT_BITS : CNT_OUT_BITS) :
                               ((LIMIT_BITS > CNT_OUT_BITS) ? LIMIT_BITS : CNT_OUT_BITS);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // Configuration
    logic [LIMIT_BITS-1:0]  char_limit_reg;

    // Sequence state
    logic [LEFT_BITS-1:0]   bytes_left_reg, bytes_left_next;
    logic [LEN_BITS-1:0]    seq_total_reg,  seq_total_next;
    logic [BYTE_BITS-1:0]   lead_reg,       lead_next;
    logic [BYTE_BITS-1:0]   second_reg,     second_next;
    logic [BYTE_BITS-1:0]   third_reg,      third_next;
    logic [COUNT_BITS-1:0]  counter_reg,    counter_next;

    // Result register
    logic                   out_valid_reg;
    logic [CP_BITS-1:0]     code_point_reg, code_point_next;
    logic [LEN_BITS-1:0]    seq_length_reg, seq_length_next;
    logic [CNT_OUT_BITS-1:0] char_count_reg, char_count_next;
    logic                   eos_reg,        eos_next;
    logic                   limit_reg,      limit_next;
    logic                   emit;

    logic                   in_xfer;
    logic                   out_xfer;
    logic                   cfg_wr;

    // Combinational helpers
    logic [LEN_BITS-1:0]    lead_len;
    logic [LEN_BITS-1:0]    pos;
    logic [BYTE_BITS-1:0]   sec_cur;
    logic [BYTE_BITS-1:0]   thr_cur;
    logic [CP_BITS-1:0]     decoded;
    logic [WIDE_BITS-1:0]   cnt_wide;
    logic [WIDE_BITS-1:0]   cnt_inc_wide;
    logic [WIDE_BITS-1:0]   lim_wide;
    logic [COUNT_BITS-1:0]  cnt_inc;

    // Handshake: accept while the output register is empty or being drained
    assign out_xfer = out_valid_reg && !out_stall;
    assign in_stall = out_valid_reg && out_stall;
    assign in_xfer  = in_valid && !in_stall;

    // APB register access
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_CHAR_LIMIT_ADDR[2]);

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_CHAR_LIMIT_ADDR[2])
        begin
            prdata = APB_DATA_BITS'(char_limit_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_limit_reg <= CHAR_LIMIT_RESET;
        end
        else if (cfg_wr)
        begin
            char_limit_reg <= pwdata[LIMIT_BITS-1:0];
        end
    end

    // Saturating counter step
    assign lim_wide = WIDE_BITS'(char_limit_reg);
    assign cnt_wide = WIDE_BITS'(counter_reg);
    assign cnt_inc  = ((cnt_wide < lim_wide) && (counter_reg != COUNT_MAX)) ?
                      counter_reg + COUNT_BITS'(1) : counter_reg;
    assign cnt_inc_wide = WIDE_BITS'(cnt_inc);

    // Decode of the completing sequence, with the current byte merged in
    assign lead_len = (data_byte < ASCII_TOP) ? LEN_BITS'(1) : leading_ones(data_byte);
    assign pos      = seq_total_reg - LEN_BITS'(bytes_left_reg);
    assign sec_cur  = (pos == LEN_BITS'(1)) ? data_byte : second_reg;
    assign thr_cur  = (pos == LEN_BITS'(2)) ? data_byte : third_reg;

    always_comb
    begin
        decoded = CP_BITS'(lead_reg);
        if ((seq_total_reg == LEN_BITS'(2)) && ((lead_reg & MASK_E0) == LEAD2_PAT) &&
            ((sec_cur & MASK_C0) == CONT_PAT))
        begin
            decoded = CP_BITS'({lead_reg[4:0] & PAY2_MASK[4:0], sec_cur[5:0] & CONT_MASK[5:0]});
        end
        else if ((seq_total_reg == LEN_BITS'(3)) && ((lead_reg & MASK_F0) == LEAD3_PAT) &&
                 ((sec_cur & MASK_C0) == CONT_PAT) && ((thr_cur & MASK_C0) == CONT_PAT))
        begin
            decoded = {lead_reg[3:0] & PAY3_MASK[3:0], sec_cur[5:0] & CONT_MASK[5:0],
                       thr_cur[5:0] & CONT_MASK[5:0]};
        end
    end

    // Next state and result for one accepted byte
    always_comb
    begin
        bytes_left_next = bytes_left_reg;
        seq_total_next  = seq_total_reg;
        lead_next       = lead_reg;
        second_next     = second_reg;
        third_next      = third_reg;
        counter_next    = counter_reg;
        emit            = 1'b0;
        code_point_next = code_point_reg;
        seq_length_next = seq_length_reg;
        char_count_next = char_count_reg;
        eos_next        = eos_reg;
        limit_next      = limit_reg;

        if (in_xfer)
        begin
            if (bytes_left_reg == '0)
            begin
                if (data_byte == '0)
                begin
                    // End of string: report the count, then clear it
                    emit            = 1'b1;
                    code_point_next = '0;
                    seq_length_next = LEN_BITS'(1);
                    char_count_next = cnt_wide[CNT_OUT_BITS-1:0];
                    eos_next        = 1'b1;
                    limit_next      = (cnt_wide >= lim_wide);
                    counter_next    = '0;
                end
                else if (lead_len <= LEN_BITS'(1))
                begin
                    // Single byte character, including a stray continuation
                    emit            = 1'b1;
                    code_point_next = CP_BITS'(data_byte);
                    seq_length_next = LEN_BITS'(1);
                    char_count_next = cnt_inc_wide[CNT_OUT_BITS-1:0];
                    eos_next        = 1'b0;
                    limit_next      = (cnt_inc_wide >= lim_wide);
                    counter_next    = cnt_inc;
                end
                else
                begin
                    // Open a multi-byte sequence
                    lead_next       = data_byte;
                    second_next     = '0;
                    third_next      = '0;
                    seq_total_next  = lead_len;
                    bytes_left_next = LEFT_BITS'(lead_len - LEN_BITS'(1));
                end
            end
            else
            begin
                second_next     = sec_cur;
                third_next      = thr_cur;
                bytes_left_next = bytes_left_reg - LEFT_BITS'(1);
                if (bytes_left_reg == LEFT_BITS'(1))
                begin
                    emit            = 1'b1;
                    code_point_next = decoded;
                    seq_length_next = seq_total_reg;
                    char_count_next = cnt_inc_wide[CNT_OUT_BITS-1:0];
                    eos_next        = 1'b0;
                    limit_next      = (cnt_inc_wide >= lim_wide);
                    counter_next    = cnt_inc;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_left_reg <= '0;
            seq_total_reg  <= '0;
            lead_reg       <= '0;
            second_reg     <= '0;
            third_reg      <= '0;
            counter_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            bytes_left_reg <= bytes_left_next;
            seq_total_reg  <= seq_total_next;
            lead_reg       <= lead_next;
            second_reg     <= second_next;
            third_reg      <= third_next;
            counter_reg    <= counter_next;
            // Load on a new result, drop after the sink takes it
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_xfer)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload of the result register, held while stalled
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            code_point_reg <= code_point_next;
            seq_length_reg <= seq_length_next;
            char_count_reg <= char_count_next;
            eos_reg        <= eos_next;
            limit_reg      <= limit_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign code_point    = code_point_reg;
    assign seq_length    = seq_length_reg;
    assign char_count    = char_count_reg;
    assign end_of_string = eos_reg;
    assign limit_reached = limit_reg;

    // A sequence in progress always has a length of at least two
    a_seq_len: assert property (@(posedge clk) disable iff (!rst_n)
        (bytes_left_reg != '0) |-> (seq_total_reg >= LEN_BITS'(2)) &&
                                   (LEN_BITS'(bytes_left_reg) < seq_total_reg))
        else $error("bytes_left exceeds sequence length");

    // A zero byte at character start clears the counter
    a_eos_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && (bytes_left_reg == '0) && (data_byte == '0)) |=> (counter_reg == '0))
        else $error("counter not cleared at end of string");

    // End-of-string results carry code point zero and length one
    a_eos_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && eos_reg) |-> (code_point_reg == '0) &&
                                       (seq_length_reg == LEN_BITS'(1)))
        else $error("malformed end-of-string result");

    // Input is taken only when the result register can accept a new result
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (!out_valid_reg || !out_stall))
        else $error("result overwritten while stalled");

endmodule

`default_nettype wire
